// ===== rtl/ecdf_pkg.sv =====
// Shared types and constants of the empirical distribution sampler.
// Used by ecdf_cell, ecdf_div and empirical_cdf_sampler; depends on nothing.
`default_nettype none

package ecdf_pkg;

    localparam int MAX_POINTS = 256;
    localparam int COUNT_W    = $clog2(MAX_POINTS + 1);
    localparam int STEP_W     = $clog2(MAX_POINTS);
    localparam int VAL_W      = 32;
    localparam int QNT_W      = 24;
    localparam int FRAC_W     = 16;
    localparam int XM_W       = FRAC_W + QNT_W;
    localparam int DY_W       = VAL_W + 1;
    localparam int NUM_W      = QNT_W + VAL_W + 1;
    localparam int DCNT_W     = $clog2(NUM_W + 1);
    localparam int TERM_W     = VAL_W + QNT_W + 3;
    localparam int ACC_W      = TERM_W + STEP_W;
    localparam int AVG_SHIFT  = 17;
    localparam int RES_W      = 42;
    localparam int HELD_W     = 9;

    localparam logic [QNT_W-1:0] LOW_RESET  = '0;
    localparam logic [QNT_W-1:0] HIGH_RESET = QNT_W'(65536);

    typedef enum logic [1:0] {
        FUNC_CLEAR   = 2'd0,
        FUNC_APPEND  = 2'd1,
        FUNC_SAMPLE  = 2'd2,
        FUNC_AVERAGE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_XMUL,
        ST_SCAN,
        ST_PROD,
        ST_DIVGO,
        ST_DIV,
        ST_AVG,
        ST_AFLUSH,
        ST_AFIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic rotate;
        logic load;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/ecdf_cell.sv =====
// One table cell: holds a (value, quantile) point and hands it to its
// neighbor while the ring rotates. Depends on ecdf_pkg.
`default_nettype none

module ecdf_cell (
    input  wire                           aclk,
    input  wire  ecdf_pkg::cell_ctrl_t    ctrl,
    input  wire  [ecdf_pkg::VAL_W-1:0]    shift_v,
    input  wire  [ecdf_pkg::QNT_W-1:0]    shift_q,
    input  wire  [ecdf_pkg::VAL_W-1:0]    load_v,
    input  wire  [ecdf_pkg::QNT_W-1:0]    load_q,
    output logic [ecdf_pkg::VAL_W-1:0]    cell_v,
    output logic [ecdf_pkg::QNT_W-1:0]    cell_q
);

    logic [ecdf_pkg::VAL_W-1:0] v_reg;
    logic [ecdf_pkg::QNT_W-1:0] q_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.rotate) begin
            v_reg <= shift_v;
            q_reg <= shift_q;
        end else if (ctrl.load) begin
            v_reg <= load_v;
            q_reg <= load_q;
        end
    end

    assign cell_v = v_reg;
    assign cell_q = q_reg;

endmodule

`default_nettype wire

// ===== rtl/ecdf_div.sv =====
// Restoring divider, one quotient bit per cycle, for the interpolation step.
// Depends on ecdf_pkg.
`default_nettype none

module ecdf_div (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           start,
    input  wire  [ecdf_pkg::NUM_W-1:0]    num,
    input  wire  [ecdf_pkg::QNT_W-1:0]    den,
    output logic [ecdf_pkg::NUM_W-1:0]    quo,
    output logic                          rem_nz,
    output logic                          done
);

    logic [ecdf_pkg::QNT_W-1:0]  rem_reg;
    logic [ecdf_pkg::NUM_W-1:0]  quo_reg;
    logic [ecdf_pkg::QNT_W-1:0]  den_reg;
    logic [ecdf_pkg::DCNT_W-1:0] cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [ecdf_pkg::QNT_W:0]    trial;
    logic                        fits;

    assign trial = {rem_reg, quo_reg[ecdf_pkg::NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ecdf_pkg::DCNT_W'(ecdf_pkg::NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            // subtract when the partial remainder covers the divisor
            rem_reg <= fits ? ecdf_pkg::QNT_W'(trial - {1'b0, den_reg})
                            : trial[ecdf_pkg::QNT_W-1:0];
            quo_reg <= {quo_reg[ecdf_pkg::NUM_W-2:0], fits};
        end
    end

    assign quo    = quo_reg;
    assign rem_nz = |rem_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

// ===== rtl/empirical_cdf_sampler.sv =====
// Empirical distribution sampler: a ring of MAX_POINTS cells holds the
// (value, quantile) table. Clear and append, and a sample or an average on
// an empty table, load the output register when accepted. A sample or an
// average rotates the whole ring once, one cell per cycle, past a single
// compare/multiply stage at the head cell; a sample whose bracketing
// interval has two distinct quantiles then also runs through the bit-serial
// divider. One transaction is in work at a time; a new transaction is taken
// only once the output register is empty or being read out.
// Depends on ecdf_pkg, ecdf_cell and ecdf_div.
`default_nettype none

module empirical_cdf_sampler (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [71:0] s_tdata,   // point_value, point_quantile, uniform_fraction
    input  wire  [1:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [55:0] m_tdata,   // result_value, points_held, zero fill
    output logic [1:0]  m_tuser    // status
);

    localparam int VW = ecdf_pkg::VAL_W;
    localparam int QW = ecdf_pkg::QNT_W;
    localparam int MP = ecdf_pkg::MAX_POINTS;
    localparam int CW = ecdf_pkg::COUNT_W;
    localparam int SW = ecdf_pkg::STEP_W;
    localparam int RW = ecdf_pkg::RES_W;
    localparam int AW = ecdf_pkg::ACC_W;

    // input fields
    logic [VW-1:0]              in_value;
    logic [QW-1:0]              in_quant;
    logic [ecdf_pkg::FRAC_W-1:0] in_frac;
    ecdf_pkg::func_t            in_func;

    assign in_value = s_tdata[31:0];
    assign in_quant = s_tdata[55:32];
    assign in_frac  = s_tdata[71:56];
    assign in_func  = ecdf_pkg::func_t'(s_tuser);

    ecdf_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg;
    logic [QW-1:0] low_reg, high_reg;
    logic [SW-1:0] step_reg;

    logic m_valid_reg;
    logic [RW-1:0] res_out_reg;
    logic [ecdf_pkg::HELD_W-1:0] held_out_reg;
    ecdf_pkg::status_t stat_out_reg;

    // control
    logic out_free, accept, imm_done, append_we, rotate_en, div_start, load_out;
    logic last_step, in_range;

    // cell ring
    ecdf_pkg::cell_ctrl_t cell_ctrl [MP];
    logic [VW-1:0] cell_v [MP];
    logic [QW-1:0] cell_q [MP];

    genvar gi;
    generate
        for (gi = 0; gi < MP; gi++) begin : g_cell
            assign cell_ctrl[gi].rotate = rotate_en;
            assign cell_ctrl[gi].load   = append_we && (count_reg == CW'(gi));
            ecdf_cell u_cell (
                .aclk    (aclk),
                .ctrl    (cell_ctrl[gi]),
                .shift_v (cell_v[(gi + 1) % MP]),
                .shift_q (cell_q[(gi + 1) % MP]),
                .load_v  (in_value),
                .load_q  (in_quant),
                .cell_v  (cell_v[gi]),
                .cell_q  (cell_q[gi])
            );
        end
    endgenerate

    // datapath registers
    logic [ecdf_pkg::FRAC_W-1:0] u_reg;
    logic [QW-1:0] x_reg;
    logic [VW-1:0] prev_v_reg, last_v_reg, y1_reg, y2_reg;
    logic [QW-1:0] prev_q_reg, x1_reg, x2_reg;
    logic found_reg, neg_reg;
    logic [ecdf_pkg::NUM_W-1:0] prod_reg;
    logic [RW-1:0] res_reg;
    logic signed [ecdf_pkg::TERM_W-1:0] t_reg;
    logic t_valid_reg;
    logic signed [AW-1:0] acc_reg;

    // divider
    logic [ecdf_pkg::NUM_W-1:0] div_quo;
    logic div_rem_nz, div_done;

    ecdf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (prod_reg),
        .den     (QW'(x2_reg - x1_reg)),
        .quo     (div_quo),
        .rem_nz  (div_rem_nz),
        .done    (div_done)
    );

    // combinational datapath pieces
    logic [ecdf_pkg::XM_W-1:0] xmul;
    logic [QW-1:0] span;
    logic [QW-1:0] dx;
    logic signed [ecdf_pkg::DY_W-1:0] dy;
    logic [ecdf_pkg::DY_W-1:0] dy_mag;
    logic [ecdf_pkg::DY_W-1:0] q_adj;
    logic [RW-1:0] delta;
    logic [VW:0] vsum;
    logic signed [QW:0] qstep;
    logic signed [ecdf_pkg::TERM_W-1:0] term;
    logic signed [AW-1:0] acc_sh, acc_tr;
    logic [RW-1:0] avg_sat;

    localparam logic signed [AW-1:0] SAT_MAX = AW'((64'sd1 <<< (RW - 1)) - 1);
    localparam logic signed [AW-1:0] SAT_MIN = -(AW'(64'sd1 <<< (RW - 1)));

    always_comb begin
        span   = high_reg - low_reg;
        xmul   = {{QW{1'b0}}, u_reg} * {{ecdf_pkg::FRAC_W{1'b0}}, span};
        dx     = x_reg - x1_reg;
        dy     = $signed({1'b0, y2_reg}) - $signed({1'b0, y1_reg});
        dy_mag = dy[ecdf_pkg::DY_W-1] ? ecdf_pkg::DY_W'(-dy) : ecdf_pkg::DY_W'(dy);
        // negative slope floors away from zero
        q_adj  = div_quo[ecdf_pkg::DY_W-1:0]
                 + ecdf_pkg::DY_W'(neg_reg && div_rem_nz);
        delta  = neg_reg ? RW'(-{{(RW-ecdf_pkg::DY_W){1'b0}}, q_adj})
                         : {{(RW-ecdf_pkg::DY_W){1'b0}}, q_adj};
        vsum   = {1'b0, cell_v[0]} + {1'b0, prev_v_reg};
        qstep  = $signed({1'b0, cell_q[0]}) - $signed({1'b0, prev_q_reg});
        term   = $signed({1'b0, vsum}) * qstep;
        acc_sh = acc_reg >>> ecdf_pkg::AVG_SHIFT;
        acc_tr = acc_sh + AW'(acc_reg[AW-1] && (|acc_reg[ecdf_pkg::AVG_SHIFT-1:0]));
        if (acc_tr > SAT_MAX) begin
            avg_sat = SAT_MAX[RW-1:0];
        end else if (acc_tr < SAT_MIN) begin
            avg_sat = SAT_MIN[RW-1:0];
        end else begin
            avg_sat = acc_tr[RW-1:0];
        end
    end

    assign in_range  = ({1'b0, step_reg} < count_reg);
    assign last_step = (step_reg == SW'(MP - 1));

    // control outputs
    always_comb begin
        out_free  = !m_valid_reg || m_tready;
        s_tready  = (state_reg == ecdf_pkg::ST_IDLE) && out_free;
        accept    = s_tvalid && s_tready;
        imm_done  = accept && ((in_func == ecdf_pkg::FUNC_CLEAR)
                            || (in_func == ecdf_pkg::FUNC_APPEND)
                            || (count_reg == '0));
        append_we = accept && (in_func == ecdf_pkg::FUNC_APPEND)
                           && (count_reg < CW'(MP));
        rotate_en = (state_reg == ecdf_pkg::ST_SCAN) || (state_reg == ecdf_pkg::ST_AVG);
        div_start = (state_reg == ecdf_pkg::ST_DIVGO);
        load_out  = imm_done || ((state_reg == ecdf_pkg::ST_DONE) && out_free);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ecdf_pkg::ST_IDLE: begin
                if (accept && !imm_done) begin
                    state_next = (in_func == ecdf_pkg::FUNC_SAMPLE) ? ecdf_pkg::ST_XMUL
                                                                    : ecdf_pkg::ST_AVG;
                end
            end
            ecdf_pkg::ST_XMUL:   state_next = ecdf_pkg::ST_SCAN;
            ecdf_pkg::ST_SCAN: begin
                if (last_step) begin
                    state_next = ecdf_pkg::ST_PROD;
                end
            end
            ecdf_pkg::ST_PROD: begin
                state_next = (found_reg && (x1_reg != x2_reg)) ? ecdf_pkg::ST_DIVGO
                                                               : ecdf_pkg::ST_DONE;
            end
            ecdf_pkg::ST_DIVGO:  state_next = ecdf_pkg::ST_DIV;
            ecdf_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = ecdf_pkg::ST_DONE;
                end
            end
            ecdf_pkg::ST_AVG: begin
                if (last_step) begin
                    state_next = ecdf_pkg::ST_AFLUSH;
                end
            end
            ecdf_pkg::ST_AFLUSH: state_next = ecdf_pkg::ST_AFIN;
            ecdf_pkg::ST_AFIN:   state_next = ecdf_pkg::ST_DONE;
            ecdf_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = ecdf_pkg::ST_IDLE;
                end
            end
            default:             state_next = ecdf_pkg::ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ecdf_pkg::ST_IDLE;
            count_reg   <= '0;
            low_reg     <= ecdf_pkg::LOW_RESET;
            high_reg    <= ecdf_pkg::HIGH_RESET;
            m_valid_reg <= 1'b0;
            t_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            t_valid_reg <= (state_reg == ecdf_pkg::ST_AVG) && in_range;
            if (accept && (in_func == ecdf_pkg::FUNC_CLEAR)) begin
                count_reg <= '0;
                low_reg   <= ecdf_pkg::LOW_RESET;
                high_reg  <= ecdf_pkg::HIGH_RESET;
            end
            if (append_we) begin
                count_reg <= count_reg + 1'b1;
                if (in_quant < low_reg) begin
                    low_reg <= in_quant;
                end
                if (in_quant > high_reg) begin
                    high_reg <= in_quant;
                end
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (imm_done) begin
            res_out_reg <= '0;
            if (in_func == ecdf_pkg::FUNC_CLEAR) begin
                held_out_reg <= '0;
                stat_out_reg <= ecdf_pkg::STAT_OK;
            end else if (in_func == ecdf_pkg::FUNC_APPEND) begin
                held_out_reg <= append_we ? count_reg + 1'b1 : count_reg;
                stat_out_reg <= append_we ? ecdf_pkg::STAT_OK : ecdf_pkg::STAT_FULL;
            end else begin
                held_out_reg <= count_reg;
                stat_out_reg <= ecdf_pkg::STAT_EMPTY;
            end
        end else if (load_out) begin
            res_out_reg  <= res_reg;
            held_out_reg <= count_reg;
            stat_out_reg <= ecdf_pkg::STAT_OK;
        end
    end

    // sample and average datapath
    always_ff @(posedge aclk) begin
        if (t_valid_reg) begin
            acc_reg <= acc_reg + AW'(t_reg);
        end
        if (accept) begin
            u_reg      <= in_frac;
            found_reg  <= 1'b0;
            prev_v_reg <= '0;
            prev_q_reg <= '0;
            step_reg   <= '0;
            acc_reg    <= '0;
        end
        case (state_reg)
            ecdf_pkg::ST_XMUL: begin
                x_reg <= low_reg + xmul[ecdf_pkg::XM_W-1:ecdf_pkg::FRAC_W];
            end
            ecdf_pkg::ST_SCAN: begin
                prev_v_reg <= cell_v[0];
                prev_q_reg <= cell_q[0];
                step_reg   <= step_reg + 1'b1;
                // latch the first bracketing interval
                if (in_range && !found_reg && (x_reg <= cell_q[0])) begin
                    found_reg <= 1'b1;
                    x1_reg    <= prev_q_reg;
                    y1_reg    <= prev_v_reg;
                    x2_reg    <= cell_q[0];
                    y2_reg    <= cell_v[0];
                end
                if ({1'b0, step_reg} == count_reg - 1'b1) begin
                    last_v_reg <= cell_v[0];
                end
            end
            ecdf_pkg::ST_PROD: begin
                neg_reg  <= dy[ecdf_pkg::DY_W-1];
                prod_reg <= {{(ecdf_pkg::NUM_W-QW){1'b0}}, dx}
                            * {{(ecdf_pkg::NUM_W-ecdf_pkg::DY_W){1'b0}}, dy_mag};
                if (!found_reg) begin
                    res_reg <= {{(RW-VW){1'b0}}, last_v_reg};
                end else begin
                    res_reg <= {{(RW-VW){1'b0}},
                                VW'(({1'b0, y1_reg} + {1'b0, y2_reg}) >> 1)};
                end
            end
            ecdf_pkg::ST_DIV: begin
                if (div_done) begin
                    res_reg <= {{(RW-VW){1'b0}}, y1_reg} + delta;
                end
            end
            ecdf_pkg::ST_AVG: begin
                prev_v_reg <= cell_v[0];
                prev_q_reg <= cell_q[0];
                step_reg   <= step_reg + 1'b1;
                t_reg      <= term;
            end
            ecdf_pkg::ST_AFIN: begin
                res_reg <= avg_sat;
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, held_out_reg, res_out_reg};
    assign m_tuser  = stat_out_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MP))
        else $error("point count past table size");

    a_bracket: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ecdf_pkg::ST_PROD && found_reg) |->
            (x1_reg <= x_reg && x_reg <= x2_reg))
        else $error("interpolation interval does not bracket x");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ecdf_pkg::ST_DIV))
        else $error("divider finished outside divide state");
`endif

endmodule

`default_nettype wire
